// ===== design/che_pkg.sv =====
// ============================================================================
// che_pkg
// Shared types and constants of the cluster head election engine: request
// and message codes, register indexes, reset defaults and the result record.
// ============================================================================
package che_pkg;

    localparam int TIMER_BITS_DEF = 24;
    localparam int ADDR_BITS_DEF  = 16;

    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 24;

    // Request types
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_MSG     = 2'd1;
    localparam logic [1:0] REQ_RECHECK = 2'd2;

    // Message kinds
    localparam logic [2:0] KIND_ELECTION = 3'd0;
    localparam logic [2:0] KIND_RESIGN   = 3'd1;
    localparam logic [2:0] KIND_JOIN     = 3'd2;
    localparam logic [2:0] KIND_ACCEPT   = 3'd3;
    localparam logic [2:0] KIND_DECLINE  = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_ADDR      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ELECTION_DELAY = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TENURE_LENGTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_JOIN_RETRY     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MEMBER_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_NEIGHBORS  = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_NODE_ADDR      = 16'd0;
    localparam logic [23:0] RST_ELECTION_DELAY = 24'd256;
    localparam logic [23:0] RST_TENURE_LENGTH  = 24'd460800;
    localparam logic [23:0] RST_JOIN_RETRY     = 24'd640;
    localparam logic [7:0]  RST_MEMBER_LIMIT   = 8'd10;
    localparam logic [7:0]  RST_MIN_NEIGHBORS  = 8'd3;

    localparam logic [15:0] VOTE_BATT_WEIGHT  = 16'd3;
    localparam logic [15:0] VOTE_NEIGH_WEIGHT = 16'd100;
    localparam logic [7:0]  COUNT_SAT         = 8'd255;

    // One processed event: up to two messages sharing the held fields
    typedef struct packed {
        logic [1:0]  msgs;
        logic [2:0]  kind0;
        logic [2:0]  kind1;
        logic [15:0] votes;
        logic [15:0] head;
        logic [15:0] member;
        logic        head_flag;
        logic [7:0]  member_of;
    } t_rec;

endpackage

// ===== design/cluster_head_election_engine.sv =====
// ============================================================================
// cluster_head_election_engine
// Sensor-node clustering engine: elections, tenure, join requests, replies.
// ============================================================================
// An event is captured in an input register and, once the result queue has
// room, processed by single-pass logic that updates the node state and writes
// one record into a two-entry result queue. Each record yields one result, or
// two when a tick both ends a tenure and fires the join timer. The input side
// takes one event per cycle while the queue has room; the output port drains
// one result per cycle while i_out_ready is high, which bounds the sustained
// rate at one result per cycle. An event's first result is valid once it has
// passed the input register and the result queue. Both ready outputs are low
// during reset; configuration transfers are taken every cycle after it.
module cluster_head_election_engine #(
    parameter int TIMER_BITS = che_pkg::TIMER_BITS_DEF,
    parameter int ADDR_BITS  = che_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [che_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [che_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // events
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_req_type,
    input  logic [2:0]                        i_msg_kind,
    input  logic [15:0]                       i_msg_votes,
    input  logic [15:0]                       i_msg_head,
    input  logic [15:0]                       i_msg_member,
    input  logic [15:0]                       i_sender_addr,
    input  logic                              i_head_known,
    input  logic [7:0]                        i_battery_level,
    input  logic [7:0]                        i_neighbor_count,
    // results
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_send_valid,
    output logic [2:0]                        o_send_kind,
    output logic [15:0]                       o_send_votes,
    output logic [15:0]                       o_send_head,
    output logic [15:0]                       o_send_member,
    output logic                              o_is_cluster_head,
    output logic [7:0]                        o_membership,
    output logic                              o_last_result
);

    localparam int CW = (TIMER_BITS > 24) ? TIMER_BITS : 24;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;
    localparam logic [TIMER_BITS-1:0] TONE = TIMER_BITS'(1);

    function automatic logic [TIMER_BITS-1:0] f_load(input logic [23:0] d);
        logic [CW-1:0] dw;
        dw = CW'(d);
        if (d == 24'd0) begin
            return TONE;
        end else if (dw > CW'(TMAX)) begin
            return TMAX;
        end else begin
            return TIMER_BITS'(d);
        end
    endfunction

    // configuration registers
    logic [15:0] r_node_addr;
    logic [23:0] r_election_delay;
    logic [23:0] r_tenure_length;
    logic [23:0] r_join_retry;
    logic [7:0]  r_member_limit;
    logic [7:0]  r_min_neighbors;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_req;
    logic [2:0]  r_kind;
    logic [15:0] r_mvotes;
    logic [15:0] r_mhead;
    logic [15:0] r_mmember;
    logic [15:0] r_sender;
    logic        r_known;
    logic [7:0]  r_batt;
    logic [7:0]  r_neigh;

    // node state
    logic                  r_head_flag,    n_head_flag;
    logic [7:0]            r_member_of,    n_member_of;
    logic [ADDR_BITS-1:0]  r_head_addr,    n_head_addr;
    logic [7:0]            r_member_count, n_member_count;
    logic [TIMER_BITS-1:0] r_et, n_et;
    logic [TIMER_BITS-1:0] r_tt, n_tt;
    logic [TIMER_BITS-1:0] r_jt, n_jt;
    logic [15:0]           r_held_votes,   n_held_votes;
    logic [15:0]           r_held_head,    n_held_head;
    logic [15:0]           r_held_member,  n_held_member;

    // result queue
    che_pkg::t_rec r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          r_sub;

    che_pkg::t_rec w_rec;
    che_pkg::t_rec w_head;
    logic          w_proc;
    logic          w_pop;
    logic          w_out_xfer;
    logic          w_space;

    logic [ADDR_BITS-1:0] w_self;
    logic [ADDR_BITS-1:0] w_sender;
    logic [7:0]           w_vote;
    logic                 w_recheck;
    logic                 w_fe, w_ft, w_fj;
    logic [1:0]           w_en;
    logic [2:0]           w_k0, w_k1;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_addr      <= che_pkg::RST_NODE_ADDR;
            r_election_delay <= che_pkg::RST_ELECTION_DELAY;
            r_tenure_length  <= che_pkg::RST_TENURE_LENGTH;
            r_join_retry     <= che_pkg::RST_JOIN_RETRY;
            r_member_limit   <= che_pkg::RST_MEMBER_LIMIT;
            r_min_neighbors  <= che_pkg::RST_MIN_NEIGHBORS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                che_pkg::CFG_NODE_ADDR:      r_node_addr      <= i_cfg_data[15:0];
                che_pkg::CFG_ELECTION_DELAY: r_election_delay <= i_cfg_data;
                che_pkg::CFG_TENURE_LENGTH:  r_tenure_length  <= i_cfg_data;
                che_pkg::CFG_JOIN_RETRY:     r_join_retry     <= i_cfg_data;
                che_pkg::CFG_MEMBER_LIMIT:   r_member_limit   <= i_cfg_data[7:0];
                che_pkg::CFG_MIN_NEIGHBORS:  r_min_neighbors  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign w_head     = r_q[r_rd_ptr];
    assign o_out_valid = (r_count != 2'd0);
    assign o_last_result = (w_head.msgs != 2'd2) || r_sub;
    assign w_out_xfer = o_out_valid && i_out_ready;
    assign w_pop      = w_out_xfer && o_last_result;
    assign w_space    = (r_count != 2'd2) || w_pop;
    assign w_proc     = r_in_valid && w_space;
    assign o_in_ready = i_rst_n && (!r_in_valid || w_space);

    always_comb begin
        o_send_valid      = (w_head.msgs != 2'd0);
        o_send_kind       = 3'd0;
        o_send_votes      = 16'd0;
        o_send_head       = 16'd0;
        o_send_member     = 16'd0;
        if (o_send_valid) begin
            o_send_kind   = r_sub ? w_head.kind1 : w_head.kind0;
            o_send_votes  = w_head.votes;
            o_send_head   = w_head.head;
            o_send_member = w_head.member;
        end
        o_is_cluster_head = w_head.head_flag;
        o_membership      = w_head.member_of;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req     <= i_req_type;
            r_kind    <= i_msg_kind;
            r_mvotes  <= i_msg_votes;
            r_mhead   <= i_msg_head;
            r_mmember <= i_msg_member;
            r_sender  <= i_sender_addr;
            r_known   <= i_head_known;
            r_batt    <= i_battery_level;
            r_neigh   <= i_neighbor_count;
        end
    end

    assign w_self   = r_node_addr[ADDR_BITS-1:0];
    assign w_sender = r_sender[ADDR_BITS-1:0];
    assign w_vote   = 8'(16'(r_batt) * che_pkg::VOTE_BATT_WEIGHT
                       + 16'(r_neigh) * che_pkg::VOTE_NEIGH_WEIGHT);

    always_comb begin
        n_head_flag    = r_head_flag;
        n_member_of    = r_member_of;
        n_head_addr    = r_head_addr;
        n_member_count = r_member_count;
        n_et           = r_et;
        n_tt           = r_tt;
        n_jt           = r_jt;
        n_held_votes   = r_held_votes;
        n_held_head    = r_held_head;
        n_held_member  = r_held_member;
        w_recheck      = 1'b0;
        w_fe           = 1'b0;
        w_ft           = 1'b0;
        w_fj           = 1'b0;
        w_en           = 2'd0;
        w_k0           = 3'd0;
        w_k1           = 3'd0;

        unique case (r_req)
            che_pkg::REQ_TICK: begin
                if (r_et != '0) begin
                    n_et = r_et - TONE;
                    w_fe = (r_et == TONE);
                end
                if (r_tt != '0) begin
                    n_tt = r_tt - TONE;
                    w_ft = (r_tt == TONE);
                end
                if (r_jt != '0) begin
                    n_jt = r_jt - TONE;
                    w_fj = (r_jt == TONE);
                end
                if (w_fe) begin
                    n_head_flag    = 1'b1;
                    n_member_count = 8'd0;
                    n_tt           = f_load(r_tenure_length);
                end
                if (w_ft && !w_fe) begin
                    n_head_flag = 1'b0;
                    w_k0        = che_pkg::KIND_RESIGN;
                    w_en        = 2'd1;
                end
                if (w_fj) begin
                    if (w_en == 2'd0) begin
                        w_k0 = che_pkg::KIND_JOIN;
                    end else begin
                        w_k1 = che_pkg::KIND_JOIN;
                    end
                    w_en = w_en + 2'd1;
                end
            end
            che_pkg::REQ_MSG: begin
                n_held_votes  = r_mvotes;
                n_held_head   = r_mhead;
                n_held_member = r_mmember;
                unique case (r_kind)
                    che_pkg::KIND_ELECTION: begin
                        if (16'(w_vote) < r_mvotes) begin
                            n_et        = '0;
                            n_head_flag = 1'b0;
                        end else if ((16'(w_vote) == r_mvotes)
                                     && (w_self[7:0] < w_sender[7:0])) begin
                            n_et        = '0;
                            n_head_flag = 1'b0;
                        end else if (r_neigh > r_min_neighbors) begin
                            n_held_votes = 16'(w_vote);
                            w_k0         = che_pkg::KIND_ELECTION;
                            w_en         = 2'd1;
                            n_et         = f_load(r_election_delay);
                        end
                    end
                    che_pkg::KIND_RESIGN: begin
                        if (w_sender == r_head_addr) begin
                            n_member_of = 8'd0;
                            w_recheck   = 1'b1;
                        end
                    end
                    che_pkg::KIND_JOIN: begin
                        if (r_head_flag) begin
                            if (r_member_count <= r_member_limit) begin
                                w_k0 = che_pkg::KIND_ACCEPT;
                                if (r_member_count != che_pkg::COUNT_SAT) begin
                                    n_member_count = r_member_count + 8'd1;
                                end
                            end else begin
                                w_k0 = che_pkg::KIND_DECLINE;
                            end
                            n_held_head   = 16'(w_self);
                            n_held_member = 16'(w_sender);
                            w_en          = 2'd1;
                        end
                    end
                    che_pkg::KIND_ACCEPT: begin
                        if (r_mmember[ADDR_BITS-1:0] == w_self) begin
                            n_member_of = r_mhead[7:0];
                            n_head_addr = w_sender;
                        end
                    end
                    che_pkg::KIND_DECLINE: begin
                        n_member_of = 8'd0;
                        n_jt        = f_load(r_join_retry);
                    end
                    default: ;
                endcase
            end
            che_pkg::REQ_RECHECK: begin
                w_recheck = 1'b1;
            end
            default: ;
        endcase

        if (w_recheck) begin
            if (r_known && !n_head_flag && (n_member_of == 8'd0)) begin
                n_jt = f_load(r_join_retry);
            end else if (!r_known && !n_head_flag && (r_neigh > r_min_neighbors)) begin
                n_held_votes = 16'(w_vote);
                w_k0         = che_pkg::KIND_ELECTION;
                w_en         = 2'd1;
                n_et         = f_load(r_election_delay);
            end
        end

        w_rec.msgs      = w_en;
        w_rec.kind0     = w_k0;
        w_rec.kind1     = w_k1;
        w_rec.votes     = n_held_votes;
        w_rec.head      = n_held_head;
        w_rec.member    = n_held_member;
        w_rec.head_flag = n_head_flag;
        w_rec.member_of = n_member_of;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_flag    <= 1'b0;
            r_member_of    <= 8'd0;
            r_head_addr    <= '0;
            r_member_count <= 8'd0;
            r_et           <= '0;
            r_tt           <= '0;
            r_jt           <= '0;
            r_held_votes   <= 16'd0;
            r_held_head    <= 16'd0;
            r_held_member  <= 16'd0;
        end else if (w_proc) begin
            r_head_flag    <= n_head_flag;
            r_member_of    <= n_member_of;
            r_head_addr    <= n_head_addr;
            r_member_count <= n_member_count;
            r_et           <= n_et;
            r_tt           <= n_tt;
            r_jt           <= n_jt;
            r_held_votes   <= n_held_votes;
            r_held_head    <= n_held_head;
            r_held_member  <= n_held_member;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_q[r_wr_ptr] <= w_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_sub    <= 1'b0;
        end else begin
            if (w_proc) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_proc && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!w_proc && w_pop) begin
                r_count <= r_count - 2'd1;
            end
            if (w_pop) begin
                r_sub <= 1'b0;
            end else if (w_out_xfer) begin
                r_sub <= 1'b1;
            end
        end
    end

endmodule

// ===== design/che_checker.sv =====
// ============================================================================
// che_checker
// Port-level checks of the cluster head election engine result channel.
// ============================================================================
module che_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_send_valid,
    input logic [2:0]  o_send_kind,
    input logic [15:0] o_send_votes,
    input logic [15:0] o_send_head,
    input logic [15:0] o_send_member,
    input logic        o_is_cluster_head,
    input logic [7:0]  o_membership,
    input logic        o_last_result
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_no_msg_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_send_valid |-> o_last_result && (o_send_kind == 3'd0)
            && (o_send_votes == 16'd0) && (o_send_head == 16'd0)
            && (o_send_member == 16'd0))
        else $error("result without message is not a clean single result");

    a_second_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && i_out_ready && !o_last_result
            |=> o_out_valid && o_send_valid)
        else $error("second message of an event missing");

    a_status_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && i_out_ready && !o_last_result
            |=> $stable(o_is_cluster_head) && $stable(o_membership)
                && $stable(o_send_votes) && $stable(o_send_head))
        else $error("status or held fields differ within one event");

endmodule

bind cluster_head_election_engine che_checker u_che_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_send_valid      (o_send_valid),
    .o_send_kind       (o_send_kind),
    .o_send_votes      (o_send_votes),
    .o_send_head       (o_send_head),
    .o_send_member     (o_send_member),
    .o_is_cluster_head (o_is_cluster_head),
    .o_membership      (o_membership),
    .o_last_result     (o_last_result)
);
